// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form
`define AES_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/aes_pkg.sv =====
`timescale 1ns / 1ps
package aes_pkg;
	localparam int unsigned STACK_DEPTH_DEF = 1024;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned POS_W = 10;
	localparam int unsigned DEPTH_W = 11;

	typedef enum logic [2:0] {
		FN_PUSH = 3'd0, FN_POP = 3'd1, FN_RDTOP = 3'd2, FN_RDBOT = 3'd3,
		FN_ADD = 3'd4, FN_SUB = 3'd5, FN_MUL = 3'd6, FN_DIV = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_RANGE = 3'd3,
		ST_FEW = 3'd4, ST_DIVZERO = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] push_value;
		logic [9:0]         position;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
		logic [10:0]        depth;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] push_value;
		logic [9:0]  position;
	} cmd_t;

	typedef enum logic [2:0] {
		BS_IDLE, BS_RD1, BS_RD2, BS_EXEC, BS_DIV, BS_OUT
	} bstate_t;
endpackage

// ===== hw/rtl/aes_ram.sv =====
`timescale 1ns / 1ps
module aes_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/aes_front.sv =====
`timescale 1ns / 1ps
module aes_front (
	input  logic              clk,
	input  logic              arst_n,
	input  aes_pkg::in_word_t in_word,
	input  logic              in_valid,
	output logic              in_stall,
	output aes_pkg::cmd_t     cmd,
	output logic              cmd_valid,
	input  logic              cmd_take
);
	// two-entry queue
	aes_pkg::cmd_t ent_q [2];
	logic          rd_q, wr_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign pop       = cmd_take && cmd_valid;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q].func       <= in_word.func;
			ent_q[wr_q].push_value <= in_word.push_value;
			ent_q[wr_q].position   <= in_word.position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== hw/rtl/aes_div.sv =====
`timescale 1ns / 1ps
module aes_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quot
);
	// restoring divide on magnitudes, one bit a cycle, then floor fix-up
	logic [31:0] q_q, r_q, dm_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [32:0] trial;
	logic [31:0] nm, dm, qs;

	assign nm    = num[31] ? (~num + 32'd1) : num;
	assign dm    = den[31] ? (~den + 32'd1) : den;
	assign trial = {r_q, q_q[31]} - {1'b0, dm_q};
	assign done  = busy_q && (cnt_q == 6'd0);
	assign qs    = neg_q ? (~q_q + 32'd1) : q_q;
	assign quot  = (neg_q && (r_q != 32'd0)) ? (qs - 32'd1) : qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			if (cnt_q == 6'd0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= nm;
			r_q   <= 32'd0;
			dm_q  <= dm;
			neg_q <= num[31] ^ den[31];
		end else if (busy_q && cnt_q != 6'd0) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= {r_q[30:0], q_q[31]};
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ===== hw/rtl/aes_back.sv =====
`timescale 1ns / 1ps
module aes_back #(
	parameter int unsigned STACK_DEPTH = aes_pkg::STACK_DEPTH_DEF,
	localparam int unsigned AW = $clog2(STACK_DEPTH),
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aes_pkg::cmd_t       cmd,
	input  logic                cmd_valid,
	output logic                cmd_take,
	output aes_pkg::out_word_t  out_word,
	output logic                out_valid,
	input  logic                out_stall
);
	aes_pkg::bstate_t st_q, st_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	aes_pkg::cmd_t    c_q;
	logic [31:0]      a_q, b_q, res_q, val_d;
	logic [2:0]       sts_d;
	logic             ram_we;
	logic [AW-1:0]    ram_wa, ram_ra;
	logic [31:0]      ram_wd, ram_rd;
	logic             dv_start, dv_done;
	logic [31:0]      dv_q;
	logic [31:0]      prod;
	logic [CW-1:0]    pos_ext;
	aes_pkg::out_word_t ob_q, ob_d;
	logic             ov_q;
	logic             ld_ob, ld_a, ld_b, ld_res, ld_c;
	logic [CW-1:0]    idx;

	aes_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	aes_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(b_q), .den(a_q),
		.done(dv_done), .quot(dv_q)
	);

	assign pos_ext   = CW'(c_q.position);
	assign prod      = a_q * ram_rd;
	assign out_valid = ov_q;
	assign out_word  = ob_q;

	always_comb begin
		idx = cnt_q - CW'(1);
		if (st_q == aes_pkg::BS_RD1 && c_q.func == aes_pkg::FN_RDTOP)
			idx = cnt_q - CW'(1) - pos_ext;
		else if (st_q == aes_pkg::BS_RD1 && c_q.func == aes_pkg::FN_RDBOT)
			idx = pos_ext;
		else if (st_q == aes_pkg::BS_RD2 || st_q == aes_pkg::BS_DIV)
			idx = cnt_q - CW'(2);
	end
	assign ram_ra = idx[AW-1:0];

	always_comb begin
		st_d     = st_q;
		cnt_d    = cnt_q;
		cmd_take = 1'b0;
		ram_we   = 1'b0;
		ram_wa   = cnt_q[AW-1:0];
		ram_wd   = c_q.push_value;
		dv_start = 1'b0;
		ld_c     = 1'b0;
		ld_a     = 1'b0;
		ld_b     = 1'b0;
		ld_res   = 1'b0;
		ld_ob    = 1'b0;
		val_d    = 32'd0;
		sts_d    = aes_pkg::ST_OK;
		case (st_q)
			aes_pkg::BS_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					ld_c     = 1'b1;
					st_d     = aes_pkg::BS_RD1;
				end
			end
			aes_pkg::BS_RD1: begin
				// read address presented; classify errors now
				st_d = aes_pkg::BS_RD2;
				case (c_q.func)
					aes_pkg::FN_PUSH: begin
						if (cnt_q >= CW'(STACK_DEPTH)) begin
							sts_d = aes_pkg::ST_FULL;
						end else begin
							ram_we = 1'b1;
							cnt_d  = cnt_q + CW'(1);
						end
						ld_ob = 1'b1;
						st_d  = aes_pkg::BS_OUT;
					end
					aes_pkg::FN_POP: begin
						if (cnt_q == '0) begin
							sts_d = aes_pkg::ST_EMPTY;
							ld_ob = 1'b1;
							st_d  = aes_pkg::BS_OUT;
						end
					end
					aes_pkg::FN_RDTOP, aes_pkg::FN_RDBOT: begin
						if (32'(c_q.position) >= 32'(cnt_q)) begin
							sts_d = aes_pkg::ST_RANGE;
							ld_ob = 1'b1;
							st_d  = aes_pkg::BS_OUT;
						end
					end
					default: begin
						if (cnt_q < CW'(2)) begin
							sts_d = aes_pkg::ST_FEW;
							ld_ob = 1'b1;
							st_d  = aes_pkg::BS_OUT;
						end
					end
				endcase
			end
			aes_pkg::BS_RD2: begin
				ld_a = 1'b1;
				if (c_q.func inside {aes_pkg::FN_POP, aes_pkg::FN_RDTOP,
						aes_pkg::FN_RDBOT}) begin
					val_d = ram_rd;
					if (c_q.func == aes_pkg::FN_POP)
						cnt_d = cnt_q - CW'(1);
					ld_ob = 1'b1;
					st_d  = aes_pkg::BS_OUT;
				end else begin
					st_d = aes_pkg::BS_EXEC;
				end
			end
			aes_pkg::BS_EXEC: begin
				ld_b = 1'b1;
				if (c_q.func == aes_pkg::FN_DIV) begin
					if (a_q == 32'd0) begin
						sts_d = aes_pkg::ST_DIVZERO;
						ld_ob = 1'b1;
						st_d  = aes_pkg::BS_OUT;
					end else begin
						st_d = aes_pkg::BS_DIV;
					end
				end else begin
					st_d = aes_pkg::BS_DIV;
				end
			end
			aes_pkg::BS_DIV: begin
				// b_q valid here; multiply result registered before use
				if (c_q.func == aes_pkg::FN_ADD)
					val_d = b_q + a_q;
				else if (c_q.func == aes_pkg::FN_SUB)
					val_d = b_q - a_q;
				else if (c_q.func == aes_pkg::FN_MUL)
					val_d = res_q;
				else
					val_d = dv_q;
				if (c_q.func != aes_pkg::FN_DIV || dv_done) begin
					ram_we = 1'b1;
					ram_wa = idx[AW-1:0];
					ram_wd = val_d;
					cnt_d  = cnt_q - CW'(1);
					ld_ob  = 1'b1;
					st_d   = aes_pkg::BS_OUT;
				end
				if (c_q.func == aes_pkg::FN_DIV && !dv_done && !res_q[0])
					dv_start = 1'b1;
				ld_res = (c_q.func == aes_pkg::FN_DIV) && !dv_done;
			end
			aes_pkg::BS_OUT: begin
				if (!ov_q)
					st_d = aes_pkg::BS_IDLE;
			end
			default: st_d = aes_pkg::BS_IDLE;
		endcase
		ob_d.value  = val_d;
		ob_d.status = sts_d;
		ob_d.depth  = 11'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= aes_pkg::BS_IDLE;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			if (ld_ob)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	// res_q: product in exec, then bit 0 flags divider started
	always_ff @(posedge clk) begin
		if (ld_c)
			c_q <= cmd;
		if (ld_a)
			a_q <= ram_rd;
		if (ld_b)
			b_q <= ram_rd;
		if (st_q == aes_pkg::BS_EXEC)
			res_q <= (c_q.func == aes_pkg::FN_DIV) ? 32'd0 : prod;
		else if (ld_res)
			res_q <= 32'd1;
		if (ld_ob)
			ob_q <= ob_d;
	end
endmodule

// ===== hw/rtl/arithmetic_evaluation_stack.sv =====
`timescale 1ns / 1ps
// Evaluation stack of 32-bit signed words (push, pop, indexed read, add, sub,
// mul, floored div). An input queue of two words takes operations while the
// execution unit works; each operation gives exactly one result word with value,
// status and depth. A push and the errors found from the depth are answered from the
// first read state; pop and reads add a second read, divide by zero adds an execute
// state, and add/sub/mul/div go on to the arithmetic state, where div waits on the
// 32-step bit-serial divider. The stack memory has one read port and returns one
// operand a cycle, and a stalled result word holds the unit until it is taken.
module arithmetic_evaluation_stack #(
	parameter int unsigned STACK_DEPTH = aes_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  aes_pkg::in_word_t  in_word,
	input  logic               in_valid,
	output logic               in_stall,
	output aes_pkg::out_word_t out_word,
	output logic               out_valid,
	input  logic               out_stall
);
	aes_pkg::cmd_t cmd;
	logic          cmd_valid, cmd_take;

	aes_front u_front (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .in_valid(in_valid),
		.in_stall(in_stall), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
	);

	aes_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .out_word(out_word), .out_valid(out_valid),
		.out_stall(out_stall)
	);
endmodule

// ===== hw/rtl/aes_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_checker (
	input logic               clk,
	input logic               arst_n,
	input aes_pkg::in_word_t  in_word,
	input logic               in_valid,
	input logic               in_stall,
	input aes_pkg::out_word_t out_word,
	input logic               out_valid,
	input logic               out_stall
);
	logic out_held, out_err;

	assign out_held = out_valid && out_stall;
	assign out_err  = out_valid && (out_word.status != aes_pkg::ST_OK);

	`AES_IMPLY(a_hold, clk, arst_n, $past(out_held), out_valid && $stable(out_word), "word lost")
	`AES_IMPLY(a_stat, clk, arst_n, out_valid, out_word.status <= aes_pkg::ST_DIVZERO, "bad status")
	`AES_IMPLY(a_errz, clk, arst_n, out_err, out_word.value == 32'sd0, "error value not zero")
	`AES_IMPLY(a_dep, clk, arst_n, out_valid, out_word.depth <= 11'(aes_pkg::STACK_DEPTH_DEF), "depth")
endmodule

bind arithmetic_evaluation_stack aes_checker u_aes_checker (.*);

// ===== tb/sv/arithmetic_evaluation_stack_test.sv =====
`timescale 1ns / 1ps
module arithmetic_evaluation_stack_test;
	localparam int DEPTH = 1024;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	aes_pkg::in_word_t in_word = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	aes_pkg::out_word_t out_word;
	logic out_valid;
	logic out_stall = 1'b0;

	arithmetic_evaluation_stack dut (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .in_valid(in_valid),
		.in_stall(in_stall), .out_word(out_word), .out_valid(out_valid),
		.out_stall(out_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [31:0] model_words [DEPTH];
	int model_count;
	aes_pkg::out_word_t pending_q[$];
	int errors = 0;
	int sent = 0;
	int got = 0;
	int n_full = 0, n_divzero = 0;

	task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, seen, want, got);
		errors++;
	endtask

	task automatic check_word(input string where, input aes_pkg::out_word_t seen,
			input aes_pkg::out_word_t want);
		if (seen.value !== want.value)
			report({where, " value"}, seen.value, want.value);
		if (seen.status !== want.status)
			report({where, " status"}, 32'(seen.status), 32'(want.status));
		if (seen.depth !== want.depth)
			report({where, " depth"}, 32'(seen.depth), 32'(want.depth));
	endtask

	function automatic logic [31:0] floor_quot(logic [31:0] num, logic [31:0] den);
		longint n, d, q;
		n = $signed(num);
		d = $signed(den);
		q = n / d;
		if ((n % d) != 0 && ((n < 0) != (d < 0)))
			q = q - 1;
		return q[31:0];
	endfunction

	function automatic aes_pkg::out_word_t stack_eval(aes_pkg::in_word_t w);
		aes_pkg::out_word_t r;
		logic [31:0] a, b, v;
		r = '0;
		v = '0;
		r.status = aes_pkg::ST_OK;
		case (aes_pkg::func_t'(w.func))
			aes_pkg::FN_PUSH: begin
				if (model_count >= DEPTH) begin
					r.status = aes_pkg::ST_FULL;
				end else begin
					model_words[model_count] = w.push_value;
					model_count++;
				end
			end
			aes_pkg::FN_POP: begin
				if (model_count == 0) begin
					r.status = aes_pkg::ST_EMPTY;
				end else begin
					model_count--;
					v = model_words[model_count];
				end
			end
			aes_pkg::FN_RDTOP, aes_pkg::FN_RDBOT: begin
				if (int'(w.position) >= model_count)
					r.status = aes_pkg::ST_RANGE;
				else if (w.func == aes_pkg::FN_RDTOP)
					v = model_words[model_count - 1 - int'(w.position)];
				else
					v = model_words[w.position];
			end
			default: begin
				if (model_count < 2) begin
					r.status = aes_pkg::ST_FEW;
				end else begin
					a = model_words[model_count - 1];
					b = model_words[model_count - 2];
					if (w.func == aes_pkg::FN_DIV && a == 0) begin
						r.status = aes_pkg::ST_DIVZERO;
					end else begin
						case (aes_pkg::func_t'(w.func))
							aes_pkg::FN_ADD: v = b + a;
							aes_pkg::FN_SUB: v = b - a;
							aes_pkg::FN_MUL: v = b * a;
							default: v = floor_quot(b, a);
						endcase
						model_count--;
						model_words[model_count - 1] = v;
					end
				end
			end
		endcase
		r.value = v;
		r.depth = model_count[10:0];
		return r;
	endfunction

	typedef struct {
		aes_pkg::in_word_t w;
		logic chk;
		aes_pkg::out_word_t want;
	} row_t;

	row_t dir_rows[$];

	function automatic row_t mk(aes_pkg::func_t f, logic [31:0] pv, logic [9:0] pos,
			logic chk, logic [31:0] v, aes_pkg::status_t s, logic [10:0] d);
		row_t r;
		r.w.func = f;
		r.w.push_value = pv;
		r.w.position = pos;
		r.chk = chk;
		r.want.value = v;
		r.want.status = s;
		r.want.depth = d;
		return r;
	endfunction

	task automatic send_word(aes_pkg::in_word_t w, logic chk, aes_pkg::out_word_t want);
		aes_pkg::out_word_t p;
		p = stack_eval(w);
		if (chk)
			check_word("table row", p, want);
		pending_q.push_back(p);
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic idle_gap(int n);
		in_valid <= 1'b0;
		in_word <= '0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		idle_gap(1);
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic aes_pkg::in_word_t rand_word(int bias);
		aes_pkg::in_word_t w;
		int r;
		r = $urandom_range(0, 99);
		w.push_value = $urandom;
		case ($urandom_range(0, 5))
			0: w.push_value = 32'h8000_0000;
			1: w.push_value = 32'hFFFF_FFFF;
			2: w.push_value = $urandom_range(0, 3);
			default: ;
		endcase
		if ($urandom_range(0, 99) < 15)
			w.position = 10'($urandom);
		else
			w.position = 10'($urandom_range(0, model_count + 1));
		if (r < bias)
			w.func = aes_pkg::FN_PUSH;
		else
			w.func = 3'($urandom_range(1, 7));
		return w;
	endfunction

	always @(posedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(0, 3) == 0) && (got % 97 > 30);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				report("unexpected word", out_word.value, 32'd0);
			end else begin
				aes_pkg::out_word_t e;
				e = pending_q.pop_front();
				check_word("result", out_word, e);
				if (e.status == aes_pkg::ST_FULL) n_full++;
				if (e.status == aes_pkg::ST_DIVZERO) n_divzero++;
			end
			got++;
		end
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		row_t r;
		int burst;
		model_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		dir_rows.push_back(mk(aes_pkg::FN_POP, 0, 0, 1, 0, aes_pkg::ST_EMPTY, 0));
		dir_rows.push_back(mk(aes_pkg::FN_RDTOP, 0, 0, 1, 0, aes_pkg::ST_RANGE, 0));
		dir_rows.push_back(mk(aes_pkg::FN_RDBOT, 0, 10'h3FF, 1, 0, aes_pkg::ST_RANGE, 0));
		dir_rows.push_back(mk(aes_pkg::FN_ADD, 0, 0, 1, 0, aes_pkg::ST_FEW, 0));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, 32'h8000_0000, 0, 1, 0, aes_pkg::ST_OK, 1));
		dir_rows.push_back(mk(aes_pkg::FN_DIV, 0, 0, 1, 0, aes_pkg::ST_FEW, 1));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, 32'hFFFF_FFFF, 10'h3FF, 1, 0,
			aes_pkg::ST_OK, 2));
		dir_rows.push_back(mk(aes_pkg::FN_RDTOP, 0, 1, 1, 32'h8000_0000, aes_pkg::ST_OK, 2));
		dir_rows.push_back(mk(aes_pkg::FN_RDBOT, 0, 1, 1, 32'hFFFF_FFFF, aes_pkg::ST_OK, 2));
		dir_rows.push_back(mk(aes_pkg::FN_RDTOP, 0, 2, 1, 0, aes_pkg::ST_RANGE, 2));
		dir_rows.push_back(mk(aes_pkg::FN_DIV, 0, 0, 1, 32'h8000_0000, aes_pkg::ST_OK, 1));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, 0, 0, 1, 0, aes_pkg::ST_OK, 2));
		dir_rows.push_back(mk(aes_pkg::FN_DIV, 0, 0, 1, 0, aes_pkg::ST_DIVZERO, 2));
		dir_rows.push_back(mk(aes_pkg::FN_POP, 0, 0, 1, 0, aes_pkg::ST_OK, 1));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, 32'h7FFF_FFFF, 0, 1, 0, aes_pkg::ST_OK, 2));
		dir_rows.push_back(mk(aes_pkg::FN_ADD, 0, 0, 1, 32'hFFFF_FFFF, aes_pkg::ST_OK, 1));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, -7, 0, 0, 0, aes_pkg::ST_OK, 0));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, 2, 0, 0, 0, aes_pkg::ST_OK, 0));
		dir_rows.push_back(mk(aes_pkg::FN_DIV, 0, 0, 0, 0, aes_pkg::ST_OK, 0));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, 3, 0, 0, 0, aes_pkg::ST_OK, 0));
		dir_rows.push_back(mk(aes_pkg::FN_SUB, 0, 0, 0, 0, aes_pkg::ST_OK, 0));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, -6, 0, 0, 0, aes_pkg::ST_OK, 0));
		dir_rows.push_back(mk(aes_pkg::FN_MUL, 0, 0, 0, 0, aes_pkg::ST_OK, 0));
		dir_rows.push_back(mk(aes_pkg::FN_PUSH, -3, 0, 0, 0, aes_pkg::ST_OK, 0));
		dir_rows.push_back(mk(aes_pkg::FN_DIV, 0, 0, 0, 0, aes_pkg::ST_OK, 0));
		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].chk, dir_rows[i].want);
		drain;

		// fill to full, hit full, read both ends
		while (model_count < DEPTH)
			send_word(rand_word(100), 1'b0, '0);
		r = mk(aes_pkg::FN_PUSH, 1, 0, 1, 0, aes_pkg::ST_FULL, 11'(DEPTH));
		send_word(r.w, r.chk, r.want);
		r = mk(aes_pkg::FN_RDTOP, 0, 10'h3FF, 0, 0, aes_pkg::ST_OK, 0);
		send_word(r.w, r.chk, r.want);
		r = mk(aes_pkg::FN_RDBOT, 0, 10'h3FF, 0, 0, aes_pkg::ST_OK, 0);
		send_word(r.w, r.chk, r.want);
		drain;

		// random bursts, push-heavy phases alternating with draining ones
		while (sent < 1300) begin
			burst = $urandom_range(1, 20);
			repeat (burst) send_word(rand_word((sent / 150) % 2 ? 25 : 55), 1'b0, '0);
			if ($urandom_range(0, 2) == 0)
				idle_gap($urandom_range(1, 12));
		end
		drain;
		repeat (60) @(posedge clk);

		$display("%0d words sent, %0d results checked, %0d full and %0d divide-by-zero hits",
			sent, got, n_full, n_divzero);
		if (errors == 0 && pending_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
